### rtl/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Shared constants, types and a helper function of the grid ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

    // Map geometry.
    localparam int MAP_COLS    = 32;
    localparam int MAP_ROWS    = 32;
    localparam int TILE_PIXELS = 64;
    localparam int SUBSTEPS    = 16;

    // Fixed point format of all coordinates.
    localparam int FRAC_BITS = 12;
    localparam int Q_ONE     = 4096;
    localparam int STEP_Q    = Q_ONE / SUBSTEPS;
    localparam int TILE_Q    = TILE_PIXELS * Q_ONE;
    localparam int TILE_SHIFT = $clog2(TILE_Q);
    localparam longint GRID_W = longint'(MAP_COLS) * TILE_Q;
    localparam longint GRID_H = longint'(MAP_ROWS) * TILE_Q;

    // Field widths.
    localparam int PLAYER_W = 23;
    localparam int TARGET_W = 25;
    localparam int ROW_F_W  = 5;
    localparam int COL_F_W  = 5;
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 11;
    localparam int HIT_W    = 11;
    localparam int DIST_W   = 24;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // Derived widths.
    localparam int COL_W   = $clog2(MAP_COLS);
    localparam int ROW_W   = $clog2(MAP_ROWS);
    localparam int ADDR_W  = $clog2(MAP_ROWS * MAP_COLS);
    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int DIFF_W  = TARGET_W + 1;
    localparam int D_W     = TARGET_W;
    localparam int GRID_BITS = $clog2((GRID_W > GRID_H) ? GRID_W : GRID_H);
    localparam int OFF_W   = (D_W > GRID_BITS + 1) ? D_W : GRID_BITS + 1;
    localparam int POS_W   = OFF_W + 2;
    localparam int Q_W     = $clog2(STEP_Q + 1);
    localparam int NUM_W   = D_W + Q_W;
    localparam int DCNT_W  = $clog2(NUM_W + 1);
    localparam int HQ_W    = (GRID_BITS > PLAYER_W) ? GRID_BITS : PLAYER_W;
    localparam int DD_W    = HQ_W + 1;
    localparam int SQ_W    = 2 * DD_W;
    localparam int RCNT_W  = $clog2(DD_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Item functions.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    // Cell kinds.
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_WALL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OTHER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEFT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 1'd1;

    // One classified item as it waits between the front and back ends.
    typedef struct packed {
        logic                is_cast;
        logic [ROW_F_W-1:0]  cell_row;
        logic [COL_F_W-1:0]  cell_col;
        logic [KIND_W-1:0]   cell_kind;
        logic                x_neg;
        logic                y_neg;
        logic                y_major;
        logic                zero_dir;
        logic [D_W-1:0]      amaj;
        logic [D_W-1:0]      amin;
        logic [TAG_W-1:0]    tag;
    } t_job;

    typedef struct packed {
        logic [TAG_W-1:0]    ray_tag;
        logic [HIT_W-1:0]    hit_x;
        logic [HIT_W-1:0]    hit_y;
        logic                wall_side;
        logic [DIST_W-1:0]   hit_distance;
        logic [STATUS_W-1:0] status;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned row,
                                                    input int unsigned col);
        return ADDR_W'(row * MAP_COLS + col);
    endfunction

endpackage

### rtl/grm_front.sv
// ----------------------------------------------------------------------------
// grm_front
// Accepts items and classifies casts: direction, major axis and magnitudes.
// ----------------------------------------------------------------------------
module grm_front
    import grm_pkg::*;
(
    input  logic                       i_valid,
    input  logic                       i_queue_full,
    input  logic                       i_func,
    input  logic [ROW_F_W-1:0]         i_cell_row,
    input  logic [COL_F_W-1:0]         i_cell_col,
    input  logic [KIND_W-1:0]          i_cell_kind,
    input  logic signed [TARGET_W-1:0] i_target_x,
    input  logic signed [TARGET_W-1:0] i_target_y,
    input  logic [TAG_W-1:0]           i_ray_index,
    input  logic [PLAYER_W-1:0]        i_player_x,
    input  logic [PLAYER_W-1:0]        i_player_y,
    output logic                       o_stall,
    output logic                       o_push,
    output t_job                       o_job
);

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [D_W-1:0]           adx;
    logic [D_W-1:0]           ady;
    logic                     y_major;

    assign dx = DIFF_W'(i_target_x) - $signed({{(DIFF_W-PLAYER_W){1'b0}}, i_player_x});
    assign dy = DIFF_W'(i_target_y) - $signed({{(DIFF_W-PLAYER_W){1'b0}}, i_player_y});
    assign adx = dx[DIFF_W-1] ? D_W'(-dx) : D_W'(dx);
    assign ady = dy[DIFF_W-1] ? D_W'(-dy) : D_W'(dy);
    assign y_major = (ady >= adx);

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_job.is_cast   = (i_func == FUNC_CAST);
        o_job.cell_row  = i_cell_row;
        o_job.cell_col  = i_cell_col;
        o_job.cell_kind = i_cell_kind;
        o_job.x_neg     = dx[DIFF_W-1];
        o_job.y_neg     = dy[DIFF_W-1];
        o_job.y_major   = y_major;
        o_job.zero_dir  = (adx == '0) && (ady == '0);
        o_job.amaj      = y_major ? ady : adx;
        o_job.amin      = y_major ? adx : ady;
        o_job.tag       = i_ray_index;
    end

endmodule

### rtl/grm_queue.sv
// ----------------------------------------------------------------------------
// grm_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module grm_queue
    import grm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/grm_isqrt.sv
// ----------------------------------------------------------------------------
// grm_isqrt
// Serial integer square root, one result bit per cycle, truncated.
// ----------------------------------------------------------------------------
module grm_isqrt
    import grm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_operand,
    output logic             o_done,
    output logic [DD_W-1:0]  o_root
);

    logic [SQ_W-1:0]   r_op;
    logic [DD_W:0]     r_rem;
    logic [DD_W-1:0]   r_root;
    logic [RCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DD_W+2:0]   rem_sh;
    logic [DD_W+2:0]   trial;
    logic              ge;

    assign rem_sh = {r_rem, r_op[SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op   <= {r_op[SQ_W-3:0], 2'b00};
            r_rem  <= ge ? (DD_W+1)'(rem_sh - trial) : (DD_W+1)'(rem_sh);
            r_root <= {r_root[DD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= RCNT_W'(DD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == RCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/grm_march.sv
// ----------------------------------------------------------------------------
// grm_march
// Back end: owns the tile map, writes cells, and marches each cast ray.
// ----------------------------------------------------------------------------
module grm_march
    import grm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_queue_empty,
    input  t_job                i_head,
    output logic                o_pop,
    input  logic [PLAYER_W-1:0] i_player_x,
    input  logic [PLAYER_W-1:0] i_player_y,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SIDE   = 8'b0001_0000,
        S_SQUARE = 8'b0010_0000,
        S_ROOT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Tile map.
    logic [KIND_W-1:0] r_map [MAP_DEPTH];
    logic [KIND_W-1:0] r_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic              map_we;

    // Current job and march state.
    t_job              r_job;
    logic [NUM_W-1:0]  r_num;
    logic [D_W:0]      r_drem;
    logic [Q_W-1:0]    r_inc_q;
    logic [DCNT_W-1:0] r_dcnt;
    logic [OFF_W-1:0]  r_maj;
    logic [OFF_W-1:0]  r_minq;
    logic [D_W-1:0]    r_minr;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic signed [POS_W-1:0] r_prev;
    logic signed [DD_W-1:0]  r_ddx;
    logic signed [DD_W-1:0]  r_ddy;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    t_result           r_res;

    logic [D_W:0]      div_sh;
    logic              div_ge;
    logic [OFF_W-1:0]  off_x;
    logic [OFF_W-1:0]  off_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic              in_grid;
    logic [D_W:0]      rem_sum;
    logic              rem_wrap;
    logic [DD_W-1:0]   root;
    logic              root_done;
    logic              root_start;
    logic [POS_W-1:0]  hxq;
    logic [POS_W-1:0]  hyq;

    // Long division of amin * STEP_Q by amaj, one quotient bit a cycle.
    assign div_sh = {r_drem[D_W-1:0], r_num[NUM_W-1]};
    assign div_ge = (div_sh >= {1'b0, r_job.amaj});

    // Position from the current offsets.
    assign off_x = r_job.y_major ? r_minq : r_maj;
    assign off_y = r_job.y_major ? r_maj : r_minq;
    assign pos_x = r_job.x_neg
                 ? $signed(POS_W'(i_player_x)) - $signed(POS_W'(off_x))
                 : $signed(POS_W'(i_player_x)) + $signed(POS_W'(off_x));
    assign pos_y = r_job.y_neg
                 ? $signed(POS_W'(i_player_y)) - $signed(POS_W'(off_y))
                 : $signed(POS_W'(i_player_y)) + $signed(POS_W'(off_y));
    assign in_grid = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                  && (POS_W'(pos_x) < POS_W'(GRID_W))
                  && (POS_W'(pos_y) < POS_W'(GRID_H));

    assign rem_sum  = {1'b0, r_minr} + {1'b0, r_job.amin == '0 ? D_W'(0) : r_drem[D_W-1:0]};
    assign rem_wrap = (rem_sum >= {1'b0, r_job.amaj});

    // Hit point truncated to whole pixels, back in Q12.12.
    assign hxq = POS_W'((r_x >>> FRAC_BITS) <<< FRAC_BITS);
    assign hyq = POS_W'((r_y >>> FRAC_BITS) <<< FRAC_BITS);

    assign o_pop       = (r_state == S_IDLE) && !i_queue_empty;
    assign map_we      = o_pop && !i_head.is_cast
                      && (32'(i_head.cell_row) < MAP_ROWS) && (32'(i_head.cell_col) < MAP_COLS);
    assign root_start  = (r_state == S_SQUARE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    always_comb begin
        case (r_state)
            S_READ:  rd_addr = cell_addr(32'(r_prev >>> TILE_SHIFT) % MAP_ROWS,
                                         32'(r_x >>> TILE_SHIFT) % MAP_COLS);
            default: rd_addr = cell_addr(32'(pos_y >>> TILE_SHIFT) % MAP_ROWS,
                                         32'(pos_x >>> TILE_SHIFT) % MAP_COLS);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[cell_addr(32'(i_head.cell_row), 32'(i_head.cell_col))] <= i_head.cell_kind;
        end
        r_rd <= r_map[rd_addr];
    end

    grm_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (root_start),
        .i_operand (r_sqx + r_sqy),
        .o_done    (root_done),
        .o_root    (root)
    );

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_head;
                r_num  <= NUM_W'(i_head.amin) * NUM_W'(STEP_Q);
                r_drem <= '0;
                r_inc_q <= '0;
                r_maj  <= '0;
                r_minq <= '0;
                r_minr <= '0;
                r_res  <= '0;
                r_res.ray_tag <= i_head.tag;
                r_res.status  <= ST_ZERO;
            end
            S_DIV: begin
                r_num   <= {r_num[NUM_W-2:0], 1'b0};
                r_drem  <= div_ge ? (div_sh - {1'b0, r_job.amaj}) : div_sh;
                r_inc_q <= {r_inc_q[Q_W-2:0], div_ge};
            end
            S_CHECK: begin
                r_x <= pos_x;
                r_y <= pos_y;
                if (r_maj == '0) begin
                    r_prev <= pos_y;
                end
                if (!in_grid) begin
                    r_res.status <= ST_LEFT;
                end
            end
            S_READ: begin
                if (r_rd == KIND_EMPTY) begin
                    r_prev <= r_y;
                    r_maj  <= r_maj + OFF_W'(STEP_Q);
                    if (rem_wrap) begin
                        r_minr <= D_W'(rem_sum - {1'b0, r_job.amaj});
                        r_minq <= r_minq + OFF_W'(r_inc_q) + 1'b1;
                    end else begin
                        r_minr <= D_W'(rem_sum);
                        r_minq <= r_minq + OFF_W'(r_inc_q);
                    end
                end else begin
                    r_res.status <= (r_rd == KIND_WALL) ? ST_WALL : ST_OTHER;
                    r_res.hit_x  <= HIT_W'(r_x >>> FRAC_BITS);
                    r_res.hit_y  <= HIT_W'(r_y >>> FRAC_BITS);
                    r_ddx <= $signed(DD_W'(hxq)) - $signed(DD_W'(i_player_x));
                    r_ddy <= $signed(DD_W'(hyq)) - $signed(DD_W'(i_player_y));
                end
            end
            S_SIDE: begin
                r_res.wall_side <= (r_rd == KIND_WALL);
                r_sqx <= SQ_W'(r_ddx * r_ddx);
                r_sqy <= SQ_W'(r_ddy * r_ddy);
            end
            S_ROOT: begin
                if (root_done) begin
                    r_res.hit_distance <= (32'(root) > 32'(2**DIST_W - 1))
                                        ? {DIST_W{1'b1}} : DIST_W'(root);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head.is_cast) begin
                        r_dcnt  <= DCNT_W'(NUM_W);
                        r_state <= i_head.zero_dir ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= in_grid ? S_READ : S_OUT;
                end
                S_READ: begin
                    r_state <= (r_rd == KIND_EMPTY) ? S_CHECK : S_SIDE;
                end
                S_SIDE: begin
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/grid_ray_march.sv
// ----------------------------------------------------------------------------
// grid_ray_march
// Tile-map ray marcher: holds a 2-bit tile map and marches cast rays from the
// player position toward a target in sixteenth-pixel steps.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  ----------------------------------------
//  in       i_in_valid / o_in_stall    func, cell_row/col/kind, target_x/y,
//                                      ray_index
//  out      o_out_valid / i_out_stall  ray_tag, hit_x/y, wall_side,
//                                      hit_distance, status
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A cell write is done by the back end as it takes the item from the queue. A cast
// runs a serial division for the minor-axis step, then the substeps of the march
// (position and grid test, then the registered map read), then the wall-side
// read, the squares and the bit-serial square root. The substep loop through
// the map memory sets the time that a long ray takes.
// Reset is synchronous and active low; it clears the queue, the sequencer, the
// output register and the player position. The map is undefined until written.
// Items are taken into a two-entry queue while the back end works, so a stall
// on the result side only stops the input once the queue has filled.
module grid_ray_march
    import grm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Item channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_func,
    input  logic [ROW_F_W-1:0]         i_cell_row,
    input  logic [COL_F_W-1:0]         i_cell_col,
    input  logic [KIND_W-1:0]          i_cell_kind,
    input  logic signed [TARGET_W-1:0] i_target_x,
    input  logic signed [TARGET_W-1:0] i_target_y,
    input  logic [TAG_W-1:0]           i_ray_index,
    // Result channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [TAG_W-1:0]           o_ray_tag,
    output logic [HIT_W-1:0]           o_hit_x,
    output logic [HIT_W-1:0]           o_hit_y,
    output logic                       o_wall_side,
    output logic [DIST_W-1:0]          o_hit_distance,
    output logic [STATUS_W-1:0]        o_status,
    // Configuration channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [PLAYER_W-1:0]        i_cfg_data
);

    logic [PLAYER_W-1:0] r_player_x;
    logic [PLAYER_W-1:0] r_player_y;
    logic                r_out_valid;
    t_result             r_out;

    logic    push;
    t_job    push_job;
    logic    queue_full;
    logic    queue_empty;
    t_job    head;
    logic    pop;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    // The configuration port is always ready; the user must write only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= '0;
            r_player_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLAYER_X: r_player_x <= i_cfg_data;
                CFG_PLAYER_Y: r_player_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    grm_front u_front (
        .i_valid      (i_in_valid),
        .i_queue_full (queue_full),
        .i_func       (i_func),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_cell_kind  (i_cell_kind),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .i_ray_index  (i_ray_index),
        .i_player_x   (r_player_x),
        .i_player_y   (r_player_y),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    grm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    grm_march u_march (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_player_x    (r_player_x),
        .i_player_y    (r_player_y),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // The output register takes a new result whenever it is empty or its
    // current transfer completes in this cycle.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ray_tag      = r_out.ray_tag;
    assign o_hit_x        = r_out.hit_x;
    assign o_hit_y        = r_out.hit_y;
    assign o_wall_side    = r_out.wall_side;
    assign o_hit_distance = r_out.hit_distance;
    assign o_status       = r_out.status;

endmodule

### tb/sv/grid_ray_march_checker.sv
// ----------------------------------------------------------------------------
// grid_ray_march_checker
// Watches the item, result and register channels of the ray marcher, keeps a
// shadow tile map and player position, and works out each expected result.
// ----------------------------------------------------------------------------
module grid_ray_march_checker
    import grm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_func,
    input  logic [ROW_F_W-1:0]   i_cell_row,
    input  logic [COL_F_W-1:0]   i_cell_col,
    input  logic [KIND_W-1:0]    i_cell_kind,
    input  logic [TARGET_W-1:0]  i_target_x,
    input  logic [TARGET_W-1:0]  i_target_y,
    input  logic [TAG_W-1:0]     i_ray_index,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_result              i_result,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PLAYER_W-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KIND_W-1:0]   tile_map [MAP_ROWS][MAP_COLS];
    logic [PLAYER_W-1:0] pos_x;
    logic [PLAYER_W-1:0] pos_y;
    t_result             hits_due [$];

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w >>= 2;
        end
        return longint'(root);
    endfunction

    // Walks the ray substep by substep exactly as the block should.
    function automatic t_result trace_ray(logic [TARGET_W-1:0] tx, logic [TARGET_W-1:0] ty,
                                          logic [TAG_W-1:0] tag);
        t_result     r;
        longint      px, py, dx, dy, adx, ady, amaj, amin;
        longint      x, y, prev_y, n, mj, mn, ox, oy, hx, hy, ddx, ddy, root;
        bit          y_major;
        logic [KIND_W-1:0] kind;
        r = '0;
        r.ray_tag = tag;
        px = longint'(pos_x);
        py = longint'(pos_y);
        dx = longint'($signed(tx)) - px;
        dy = longint'($signed(ty)) - py;
        if (dx == 0 && dy == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        y_major = (ady >= adx);
        amaj = y_major ? ady : adx;
        amin = y_major ? adx : ady;
        x = px;
        y = py;
        prev_y = py;
        n = 0;
        forever begin
            if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) begin
                r.status = ST_LEFT;
                return r;
            end
            kind = tile_map[int'(y / TILE_Q)][int'(x / TILE_Q)];
            if (kind != KIND_EMPTY) break;
            prev_y = y;
            n++;
            mj = n * STEP_Q;
            mn = (mj * amin) / amaj;
            ox = y_major ? mn : mj;
            oy = y_major ? mj : mn;
            x = px + ((dx < 0) ? -ox : ox);
            y = py + ((dy < 0) ? -oy : oy);
        end
        r.status = (kind == KIND_WALL) ? ST_WALL : ST_OTHER;
        hx = x >>> FRAC_BITS;
        hy = y >>> FRAC_BITS;
        ddx = hx * Q_ONE - px;
        ddy = hy * Q_ONE - py;
        root = int_sqrt(longint'(ddx * ddx + ddy * ddy));
        r.hit_x = HIT_W'(hx);
        r.hit_y = HIT_W'(hy);
        r.wall_side = (tile_map[int'(prev_y / TILE_Q)][int'((hx * Q_ONE) / TILE_Q)]
                       == KIND_WALL);
        r.hit_distance = (root > longint'(24'hFFFFFF)) ? 24'hFFFFFF : DIST_W'(root);
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want, int tag);
        $display("MISMATCH ray %0d: %s is %0d, expected %0d (t=%0t)", tag, what, got, want,
                 $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pos_x = '0;
            pos_y = '0;
            hits_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PLAYER_X) pos_x = i_cfg_data;
                else pos_y = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (hits_due.size() == 0) begin
                    $display("MISMATCH: result for ray %0d with none outstanding",
                             i_result.ray_tag);
                    o_fail_count++;
                end else begin
                    want = hits_due.pop_front();
                    if (i_result.ray_tag != want.ray_tag)
                        flag_mismatch("ray_tag", i_result.ray_tag, want.ray_tag, want.ray_tag);
                    if (i_result.status != want.status)
                        flag_mismatch("status", i_result.status, want.status, want.ray_tag);
                    if (i_result.hit_x != want.hit_x)
                        flag_mismatch("hit_x", i_result.hit_x, want.hit_x, want.ray_tag);
                    if (i_result.hit_y != want.hit_y)
                        flag_mismatch("hit_y", i_result.hit_y, want.hit_y, want.ray_tag);
                    if (i_result.wall_side != want.wall_side)
                        flag_mismatch("wall_side", i_result.wall_side, want.wall_side,
                                      want.ray_tag);
                    if (i_result.hit_distance != want.hit_distance)
                        flag_mismatch("hit_distance", i_result.hit_distance,
                                      want.hit_distance, want.ray_tag);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_WRITE) tile_map[i_cell_row][i_cell_col] = i_cell_kind;
                else hits_due.push_back(trace_ray(i_target_x, i_target_y, i_ray_index));
            end
        end
        o_pending = hits_due.size();
    end

endmodule

### tb/sv/grid_ray_march_tb.sv
// ----------------------------------------------------------------------------
// grid_ray_march_tb
// Fills the parts of the tile map that rays can reach, then casts directed and
// random rays from a range of player positions while both channels idle at
// random; a checker module predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module grid_ray_march_tb;
    import grm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // A long ray crosses the whole grid substep by substep; the limit allows
    // every ray to be that long several times over.
    localparam longint CYCLE_LIMIT = 40_000_000;
    // Cycles allowed for the back end to finish trailing cell writes.
    localparam int SETTLE_CYCLES = 64;
    // Length of the long hold-off on the result side.
    localparam int HOLD_CYCLES = 30000;
    // Half a tile, in Q12.12: the offset of a tile's centre from its corner.
    localparam int HALF_TILE_Q = TILE_Q / 2;
    // Side of a corner region in tiles; its innermost row and column are
    // always occupied, so rays from inside never reach an unwritten cell.
    localparam int REGION_TILES = 4;
    // Casts in each random phase.
    localparam int CASTS_PER_PHASE = 5;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_func;
    logic [ROW_F_W-1:0]         i_cell_row;
    logic [COL_F_W-1:0]         i_cell_col;
    logic [KIND_W-1:0]          i_cell_kind;
    logic signed [TARGET_W-1:0] i_target_x;
    logic signed [TARGET_W-1:0] i_target_y;
    logic [TAG_W-1:0]           i_ray_index;
    logic                       o_out_valid;
    logic                       i_out_stall;
    t_result                    out_word;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [PLAYER_W-1:0]        i_cfg_data;

    int     fail_count;
    int     rays_pending;
    int     results_seen;
    longint cycle_count;
    int     rays_cast;
    int     tiles_written;
    bit     in_taken;
    bit     cfg_taken;
    bit     quiet;
    bit     hold_req;

    grid_ray_march DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_cell_kind    (i_cell_kind),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_ray_index    (i_ray_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ray_tag      (out_word.ray_tag),
        .o_hit_x        (out_word.hit_x),
        .o_hit_y        (out_word.hit_y),
        .o_wall_side    (out_word.wall_side),
        .o_hit_distance (out_word.hit_distance),
        .o_status       (out_word.status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    grid_ray_march_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_cell_kind    (i_cell_kind),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_ray_index    (i_ray_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result       (out_word),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (rays_pending),
        .o_results_seen (results_seen)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Record at each rising edge whether a transfer took place on the item
    // and register channels. The driving processes read these flags at the
    // following falling edge, so they never race the block's own updates.
    always @(posedge i_clk) begin
        in_taken  <= i_in_valid && !o_in_stall;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
    end

    // Watchdog: a run that overruns the limit is a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d rays outstanding", cycle_count,
                     rays_pending);
            $display("** grid_ray_march: FAILED **");
            $finish;
        end
    end

    // Result-side stalls: short random bursts, or one long hold-off when the
    // stimulus asks for it, so that the block's queue fills and it stalls the
    // item channel in turn. In the quiet final part there are no stalls.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req    = 1'b0;
                i_out_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Offers one item and holds it steady until the block takes it. A random
    // gap may come first, unless the run is in its quiet part.
    task automatic offer_item(logic func, logic [ROW_F_W-1:0] row, logic [COL_F_W-1:0] col,
                              logic [KIND_W-1:0] kind, logic [TARGET_W-1:0] tx,
                              logic [TARGET_W-1:0] ty, logic [TAG_W-1:0] tag);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_func      = func;
        i_cell_row  = row;
        i_cell_col  = col;
        i_cell_kind = kind;
        i_target_x  = tx;
        i_target_y  = ty;
        i_ray_index = tag;
        do @(negedge i_clk); while (!in_taken);
        i_in_valid = 1'b0;
    endtask

    // A cell write; the target and tag fields carry random noise.
    task automatic write_tile(int row, int col, logic [KIND_W-1:0] kind);
        offer_item(FUNC_WRITE, ROW_F_W'(row), COL_F_W'(col), kind, TARGET_W'($urandom),
                   TARGET_W'($urandom), TAG_W'($urandom));
        tiles_written++;
    endtask

    // A cast; the cell fields carry random noise.
    task automatic cast_ray(logic [TARGET_W-1:0] tx, logic [TARGET_W-1:0] ty,
                            logic [TAG_W-1:0] tag);
        offer_item(FUNC_CAST, ROW_F_W'($urandom), COL_F_W'($urandom), KIND_W'($urandom),
                   tx, ty, tag);
        rays_cast++;
    endtask

    // Random cell contents: half empty, then walls, then the other kinds.
    function automatic logic [KIND_W-1:0] random_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return KIND_EMPTY;
        if (pick < 80) return KIND_WALL;
        if (pick < 92) return KIND_W'(2);
        return KIND_W'(3);
    endfunction

    // Random occupied cell: mostly walls, sometimes the other kinds.
    function automatic logic [KIND_W-1:0] random_block();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return KIND_WALL;
        if (pick < 9) return KIND_W'(2);
        return KIND_W'(3);
    endfunction

    // Map row or column of a corner region, counted from the grid edge.
    function automatic int region_row(bit far_side, int idx);
        return far_side ? (MAP_ROWS - 1 - idx) : idx;
    endfunction

    function automatic int region_col(bit far_side, int idx);
        return far_side ? (MAP_COLS - 1 - idx) : idx;
    endfunction

    // Writes a corner region: random cells inside, occupied cells on its
    // inner row and column.
    task automatic fill_region(bit far_r, bit far_c);
        for (int i = 0; i < REGION_TILES; i++)
            for (int j = 0; j < REGION_TILES; j++)
                write_tile(region_row(far_r, i), region_col(far_c, j),
                           (i == REGION_TILES - 1 || j == REGION_TILES - 1)
                           ? random_block() : random_kind());
    endtask

    // Random coordinate inside the open part of a corner region.
    function automatic logic [PLAYER_W-1:0] region_coord(bit far_side, longint extent);
        int span;
        span = (REGION_TILES - 1) * TILE_Q;
        if (far_side)
            return PLAYER_W'(extent - 1 - longint'($urandom_range(0, span - 1)));
        return PLAYER_W'($urandom_range(0, span - 1));
    endfunction

    // Waits until every cast has returned its result, then lets trailing
    // cell writes through the back end.
    task automatic drain();
        while (rays_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLAYER_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    // Moves the player; only ever called with the block idle.
    task automatic place_player(logic [PLAYER_W-1:0] px, logic [PLAYER_W-1:0] py);
        drain();
        write_reg(CFG_PLAYER_X, px);
        write_reg(CFG_PLAYER_Y, py);
    endtask

    function automatic logic [PLAYER_W-1:0] tile_centre(int idx);
        return PLAYER_W'(idx * TILE_Q + HALF_TILE_Q);
    endfunction

    // Random target: mostly inside the grid, sometimes anywhere in the field.
    function automatic logic [TARGET_W-1:0] random_target();
        if ($urandom_range(0, 9) < 7) return TARGET_W'($urandom_range(0, 8388607));
        return TARGET_W'($urandom);
    endfunction

    initial begin
        logic [PLAYER_W-1:0] centre;
        bit                  far_c;
        bit                  far_r;
        bit                  far_xs [4];
        bit                  far_ys [4];

        rays_cast     = 0;
        tiles_written = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = FUNC_WRITE;
        i_cell_row    = '0;
        i_cell_col    = '0;
        i_cell_kind   = KIND_EMPTY;
        i_target_x    = '0;
        i_target_y    = '0;
        i_ray_index   = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PLAYER_X;
        i_cfg_data    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // The four corner regions, each closed off towards the middle, so a
        // ray from inside one either stops there or leaves the grid.
        fill_region(1'b0, 1'b0);
        fill_region(1'b1, 1'b1);
        fill_region(1'b1, 1'b0);
        fill_region(1'b0, 1'b1);

        // Fixed scenery round tile (16,16): a corridor out of the grid to the
        // east, a wall to the west hit side-on, a wall below reached along y,
        // a kind-3 cell above, walls on the diagonals, and two occupied cells
        // in the first corner region for the player to sit in.
        for (int c = 13; c < MAP_COLS; c++) write_tile(16, c, KIND_EMPTY);
        write_tile(16, 12, KIND_WALL);
        for (int r = 17; r < 20; r++) write_tile(r, 16, KIND_EMPTY);
        write_tile(20, 16, KIND_WALL);
        write_tile(15, 16, KIND_W'(3));
        write_tile(15, 15, KIND_WALL);
        write_tile(15, 17, KIND_WALL);
        write_tile(17, 15, KIND_WALL);
        write_tile(17, 17, KIND_WALL);
        write_tile(2, 2, KIND_WALL);
        write_tile(3, 3, KIND_W'(2));

        // Directed casts from the centre of tile (16,16).
        centre = tile_centre(16);
        place_player(centre, centre);
        cast_ray(TARGET_W'(centre + 40000), TARGET_W'(centre), TAG_W'(0));
        cast_ray(TARGET_W'(centre - 40000), TARGET_W'(centre), TAG_W'(2047));
        cast_ray(TARGET_W'(centre), TARGET_W'(centre + 1), TAG_W'(1));
        cast_ray(TARGET_W'(centre), TARGET_W'(centre - 9000), TAG_W'(2));
        cast_ray(TARGET_W'(centre), TARGET_W'(centre), TAG_W'(3));
        cast_ray(TARGET_W'(centre + 1), TARGET_W'(centre), TAG_W'(4));
        cast_ray(TARGET_W'(-16777216), TARGET_W'(-16777216), TAG_W'(5));
        cast_ray(TARGET_W'(16777215), TARGET_W'(16777215), TAG_W'(6));
        cast_ray(TARGET_W'(16777215), TARGET_W'(-16777216), TAG_W'(7));
        cast_ray(TARGET_W'(-16777216), TARGET_W'(16777215), TAG_W'(8));
        cast_ray(TARGET_W'(centre + 3000), TARGET_W'(centre + 7000), TAG_W'(9));
        cast_ray(TARGET_W'(centre - 5000), TARGET_W'(centre + 5000), TAG_W'(10));

        // The player standing inside a wall, then inside another occupied cell.
        place_player(tile_centre(2), tile_centre(2));
        cast_ray(random_target(), random_target(), TAG_W'(11));
        place_player(PLAYER_W'(tile_centre(3) + 1), PLAYER_W'(tile_centre(3) - 1));
        cast_ray(random_target(), random_target(), TAG_W'(12));

        // Random phases: the exact grid corners first, then random positions,
        // each inside one of the corner regions.
        far_xs = '{1'b0, 1'b1, 1'b0, 1'b1};
        far_ys = '{1'b0, 1'b1, 1'b1, 1'b0};
        for (int ph = 0; ph < 7; ph++) begin
            far_c = far_xs[ph % 4];
            far_r = far_ys[ph % 4];
            if (ph < 4)
                place_player(far_c ? PLAYER_W'(GRID_W - 1) : '0,
                             far_r ? PLAYER_W'(GRID_H - 1) : '0);
            else
                place_player(region_coord(far_c, GRID_W), region_coord(far_r, GRID_H));
            // The last phase runs without any idling on either side.
            if (ph == 6) quiet = 1'b1;
            // In one phase the result side holds off for a long stretch while
            // casts keep coming, so the queue fills and the input stalls.
            if (ph == 4) hold_req = 1'b1;
            for (int k = 0; k < CASTS_PER_PHASE; k++) begin
                if ($urandom_range(0, 6) == 0)
                    write_tile(region_row(far_r, $urandom_range(0, REGION_TILES - 2)),
                               region_col(far_c, $urandom_range(0, REGION_TILES - 2)),
                               random_kind());
                cast_ray(random_target(), random_target(), TAG_W'($urandom));
            end
        end

        // Wait for the last results and a little beyond.
        while (rays_pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Covered %0d cell writes and %0d rays from 10 player positions.",
                 tiles_written, rays_cast);
        $display("Checked %0d results with %0d mismatches in %0d cycles.", results_seen,
                 fail_count, cycle_count);
        if (fail_count == 0 && rays_pending == 0) begin
            $display("** grid_ray_march: PASSED **");
        end else begin
            $display("** grid_ray_march: FAILED **");
        end
        $finish;
    end

endmodule
